FILE: rtl/frame_rate_resample_picker_assert.svh
// Assertion macros for the frame rate resample picker.
// Used by the top level; depends on nothing else.
`ifndef FRAME_RATE_RESAMPLE_PICKER_ASSERT_SVH
`define FRAME_RATE_RESAMPLE_PICKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRP_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRP_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/frp_pkg.sv
// Shared types and constants of the frame rate resample picker.
// Used by the controller, the datapath, the divider and the top level.
package frp_pkg;

	localparam int PTS_W    = 63;
	localparam int IDX_W    = 32;
	localparam int NUM_W    = 20;
	localparam int DEN_W    = 10;
	localparam int MODE_W   = 2;
	localparam int CHOICE_W = 2;
	localparam int WGT_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int K_W      = 30;
	localparam int P_W      = 62;
	localparam int T_W      = 64;
	localparam int BIS_W    = 33;
	localparam int RND_W    = 27;
	localparam int WSTEP_W  = 4;

	localparam logic [NUM_W-1:0] US_PER_S   = 20'd1000000;
	localparam logic [RND_W-1:0] ROUND_SCALE = 27'd100;
	localparam logic [RND_W-1:0] ROUND_THR   = 27'd51;
	localparam logic [WSTEP_W-1:0] WGT_STEPS = 4'd9;
	localparam logic [WGT_W-1:0] WGT_FULL    = 9'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

	localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;

	localparam logic [CHOICE_W-1:0] CH_OLDER = 2'd0;
	localparam logic [CHOICE_W-1:0] CH_NEWER = 2'd1;
	localparam logic [CHOICE_W-1:0] CH_BLEND = 2'd2;

	// Output tdata layout, lowest bit first.
	localparam int PTS_LSB    = 0;
	localparam int IDX_LSB    = PTS_LSB + PTS_W;
	localparam int CHOICE_LSB = IDX_LSB + IDX_W;
	localparam int WO_LSB     = CHOICE_LSB + CHOICE_W;
	localparam int WN_LSB     = WO_LSB + WGT_W;
	localparam int OUT_BITS   = WN_LSB + WGT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_DATA_W  = ((PTS_W + 7) / 8) * 8;

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_MUL1   = 16'b0000_0000_0000_0010,
		S_MUL2   = 16'b0000_0000_0000_0100,
		S_DIVGO  = 16'b0000_0000_0000_1000,
		S_DIV    = 16'b0000_0000_0001_0000,
		S_RND    = 16'b0000_0000_0010_0000,
		S_ADD    = 16'b0000_0000_0100_0000,
		S_TEST   = 16'b0000_0000_1000_0000,
		S_DIFF   = 16'b0000_0001_0000_0000,
		S_SUM    = 16'b0000_0010_0000_0000,
		S_WGTGO  = 16'b0000_0100_0000_0000,
		S_WGT    = 16'b0000_1000_0000_0000,
		S_CHOOSE = 16'b0001_0000_0000_0000,
		S_PUSH   = 16'b0010_0000_0000_0000,
		S_BISM   = 16'b0100_0000_0000_0000,
		S_SPARE  = 16'b1000_0000_0000_0000
	} frp_state_t;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'b001,
		PH_PROBE  = 3'b010,
		PH_BISECT = 3'b100
	} frp_phase_t;

	typedef struct packed {
		logic load_in;
		logic mul1;
		logic mul2;
		logic use_mid;
		logic div_start;
		logic rnd;
		logic add;
		logic dcalc;
		logic sum;
		logic wgt_start;
		logic choose;
		logic bis_init;
		logic bis_lo;
		logic bis_hi;
		logic bis_mid;
		logic idx_from_hi;
		logic push;
		logic push_last;
		logic push_ovf;
	} frp_cmd_t;

	typedef struct packed {
		logic primed;
		logic div_done;
		logic wgt_done;
		logic due;
		logic bis_more;
		logic out_free;
	} frp_status_t;

endpackage

FILE: rtl/frp_divider.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on frp_pkg for the operand widths.
module frp_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [frp_pkg::P_W-1:0]     dividend,
	input  logic [frp_pkg::NUM_W-1:0]   divisor,
	output logic [frp_pkg::P_W-1:0]     quo,
	output logic [frp_pkg::NUM_W-1:0]   rem,
	output logic                        done
);

	localparam int CNT_W = $clog2(frp_pkg::P_W);

	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic [frp_pkg::P_W-1:0]     quo_q;
	logic [frp_pkg::NUM_W-1:0]   rem_q;
	logic [frp_pkg::NUM_W:0]     rem_sh;
	logic [frp_pkg::NUM_W:0]     rem_sub;
	logic                        ge;

	assign rem_sh  = {rem_q, quo_q[frp_pkg::P_W-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign rem_sub = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(frp_pkg::P_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[frp_pkg::P_W-2:0], ge};
			rem_q <= rem_sub[frp_pkg::NUM_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = !busy_q;

endmodule

FILE: rtl/frp_datapath.sv
// Datapath: configuration, frame times, wanted time evaluation, weights,
// pending result and output register. Depends on frp_pkg and frp_divider.
module frp_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [frp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [frp_pkg::NUM_W-1:0]         cfg_wdata,
	input  logic [frp_pkg::PTS_W-1:0]         in_pts,
	input  frp_pkg::frp_cmd_t                 cmd,
	output frp_pkg::frp_status_t              st,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [frp_pkg::OUT_DATA_W-1:0]    out_data,
	output logic                              out_last,
	output logic                              out_ovf
);

	logic [frp_pkg::NUM_W-1:0]   rate_num_q;
	logic [frp_pkg::DEN_W-1:0]   rate_den_q;
	logic [frp_pkg::MODE_W-1:0]  mode_q;
	logic                        primed_q;
	logic [frp_pkg::PTS_W-1:0]   base_q, older_q, newer_q;
	logic [frp_pkg::IDX_W-1:0]   idx_q;
	logic [frp_pkg::BIS_W-1:0]   lo_q, hi_q, mid_q, span;
	logic [frp_pkg::K_W-1:0]     k_q;
	logic [frp_pkg::P_W-1:0]     p_q;
	logic [frp_pkg::IDX_W-1:0]   n_sel;
	logic [frp_pkg::NUM_W-1:0]   num_eff;
	logic [frp_pkg::P_W-1:0]     div_quo;
	logic [frp_pkg::NUM_W-1:0]   div_rem;
	logic                        div_done;
	logic                        rbit_q;
	logic [frp_pkg::T_W-1:0]     t_q, older_x, newer_x;
	logic [frp_pkg::T_W-1:0]     d1_q, d2_q, s_q;
	logic                        early_q, lt_q;
	logic [frp_pkg::T_W-1:0]     wrem_o_q, wrem_n_q;
	logic [frp_pkg::T_W:0]       sh_o, sh_n, sub_o, sub_n;
	logic                        ge_o, ge_n, wge_o_q, wge_n_q;
	logic [frp_pkg::WGT_W-1:0]   wq_o_q, wq_n_q, wo, wn;
	logic [frp_pkg::WGT_W:0]     wo_r, wn_r;
	logic [frp_pkg::WSTEP_W-1:0] wcnt_q;
	logic [frp_pkg::PTS_W-1:0]   pend_pts_q;
	logic [frp_pkg::IDX_W-1:0]   pend_idx_q;
	logic [frp_pkg::CHOICE_W-1:0] pend_ch_q, ch;
	logic [frp_pkg::WGT_W-1:0]   pend_wo_q, pend_wn_q, sel_wo, sel_wn;
	logic                        out_valid_q, out_last_q, out_ovf_q;
	logic [frp_pkg::OUT_DATA_W-1:0] out_data_q;

	assign num_eff = (rate_num_q == '0) ? frp_pkg::NUM_W'(1) : rate_num_q;
	assign n_sel   = cmd.use_mid ? mid_q[frp_pkg::IDX_W-1:0] : idx_q;
	assign older_x = {1'b0, older_q};
	assign newer_x = {1'b0, newer_q};
	assign span    = hi_q - lo_q;

	frp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (p_q),
		.divisor  (num_eff),
		.quo      (div_quo),
		.rem      (div_rem),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_num_q <= frp_pkg::NUM_W'(25000);
			rate_den_q <= frp_pkg::DEN_W'(1000);
			mode_q     <= frp_pkg::MODE_NEAREST;
			primed_q   <= 1'b0;
			base_q     <= '0;
			older_q    <= '0;
			newer_q    <= '0;
			idx_q      <= '0;
			wcnt_q     <= frp_pkg::WGT_STEPS;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					frp_pkg::CFG_RATE_NUM: rate_num_q <= cfg_wdata;
					frp_pkg::CFG_RATE_DEN: rate_den_q <= cfg_wdata[frp_pkg::DEN_W-1:0];
					frp_pkg::CFG_MODE:     mode_q <= cfg_wdata[frp_pkg::MODE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				older_q <= newer_q;
				newer_q <= in_pts;
				if (!primed_q) begin
					base_q   <= in_pts;
					primed_q <= 1'b1;
				end
			end
			if (cmd.choose) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.idx_from_hi) begin
				idx_q <= hi_q[frp_pkg::IDX_W-1:0];
			end
			if (cmd.wgt_start) begin
				wcnt_q <= '0;
			end else if (wcnt_q != frp_pkg::WGT_STEPS) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Weight steps: one bit of 2*256*a/s per cycle for each frame.
	assign sh_o  = {wrem_o_q, 1'b0};
	assign sh_n  = {wrem_n_q, 1'b0};
	assign ge_o  = sh_o >= {1'b0, s_q};
	assign ge_n  = sh_n >= {1'b0, s_q};
	assign sub_o = ge_o ? (sh_o - {1'b0, s_q}) : sh_o;
	assign sub_n = ge_n ? (sh_n - {1'b0, s_q}) : sh_n;
	assign wo_r  = {1'b0, wq_o_q} + 1'b1;
	assign wn_r  = {1'b0, wq_n_q} + 1'b1;
	assign wo    = wge_o_q ? frp_pkg::WGT_FULL : wo_r[frp_pkg::WGT_W:1];
	assign wn    = wge_n_q ? frp_pkg::WGT_FULL : wn_r[frp_pkg::WGT_W:1];

	always_comb begin
		if (early_q) begin
			ch = frp_pkg::CH_OLDER; sel_wo = frp_pkg::WGT_FULL; sel_wn = '0;
		end else if (mode_q == frp_pkg::MODE_NEAREST) begin
			if (lt_q) begin
				ch = frp_pkg::CH_OLDER; sel_wo = frp_pkg::WGT_FULL; sel_wn = '0;
			end else begin
				ch = frp_pkg::CH_NEWER; sel_wo = '0; sel_wn = frp_pkg::WGT_FULL;
			end
		end else if (s_q == '0) begin
			ch = frp_pkg::CH_NEWER; sel_wo = '0; sel_wn = frp_pkg::WGT_FULL;
		end else begin
			sel_wo = wo;
			sel_wn = wn;
			if (wo == '0) begin
				ch = frp_pkg::CH_NEWER;
			end else if (wn == '0) begin
				ch = frp_pkg::CH_OLDER;
			end else begin
				ch = frp_pkg::CH_BLEND;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			k_q <= frp_pkg::K_W'(rate_den_q) * frp_pkg::K_W'(frp_pkg::US_PER_S);
		end
		if (cmd.mul2) begin
			p_q <= frp_pkg::P_W'(k_q) * frp_pkg::P_W'(n_sel);
		end
		if (cmd.rnd) begin
			rbit_q <= (frp_pkg::RND_W'(div_rem) * frp_pkg::ROUND_SCALE)
				>= (frp_pkg::RND_W'(num_eff) * frp_pkg::ROUND_THR);
		end
		if (cmd.add) begin
			t_q <= frp_pkg::T_W'(base_q) + frp_pkg::T_W'(div_quo) + frp_pkg::T_W'(rbit_q);
		end
		if (cmd.dcalc) begin
			d1_q    <= (t_q > older_x) ? (t_q - older_x) : (older_x - t_q);
			d2_q    <= (t_q > newer_x) ? (t_q - newer_x) : (newer_x - t_q);
			early_q <= (t_q < older_x) && (t_q < newer_x);
		end
		if (cmd.sum) begin
			s_q  <= d1_q + d2_q;
			lt_q <= d1_q < d2_q;
		end
		if (cmd.wgt_start) begin
			wrem_o_q <= d2_q;
			wrem_n_q <= d1_q;
			wge_o_q  <= d2_q >= s_q;
			wge_n_q  <= d1_q >= s_q;
			wq_o_q   <= '0;
			wq_n_q   <= '0;
		end else if (wcnt_q != frp_pkg::WGT_STEPS) begin
			wrem_o_q <= sub_o[frp_pkg::T_W-1:0];
			wrem_n_q <= sub_n[frp_pkg::T_W-1:0];
			wq_o_q   <= {wq_o_q[frp_pkg::WGT_W-2:0], ge_o};
			wq_n_q   <= {wq_n_q[frp_pkg::WGT_W-2:0], ge_n};
		end
		if (cmd.choose) begin
			pend_pts_q <= t_q[frp_pkg::PTS_W-1:0];
			pend_idx_q <= idx_q;
			pend_ch_q  <= ch;
			pend_wo_q  <= sel_wo;
			pend_wn_q  <= sel_wn;
		end
		if (cmd.bis_init) begin
			lo_q <= {1'b0, idx_q};
			hi_q <= {1'b1, frp_pkg::IDX_W'(0)};
		end else if (cmd.bis_lo) begin
			lo_q <= mid_q;
		end else if (cmd.bis_hi) begin
			hi_q <= mid_q;
		end
		if (cmd.bis_mid) begin
			mid_q <= lo_q + (span >> 1);
		end
		if (cmd.push) begin
			out_data_q <= frp_pkg::OUT_DATA_W'({pend_wn_q, pend_wo_q, pend_ch_q,
				pend_idx_q, pend_pts_q});
			out_last_q <= cmd.push_last;
			out_ovf_q  <= cmd.push_ovf;
		end
	end

	assign st.primed   = primed_q;
	assign st.div_done = div_done;
	assign st.wgt_done = (wcnt_q == frp_pkg::WGT_STEPS);
	assign st.due      = !((t_q > older_x) && (t_q > newer_x));
	assign st.bis_more = span > frp_pkg::BIS_W'(1);
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

FILE: rtl/frp_ctrl.sv
// Controller state machine: sequences the wanted time evaluation, the
// burst loop and the index bisection. Depends on frp_pkg.
module frp_ctrl #(
	parameter int MAX_BURST = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  frp_pkg::frp_status_t st,
	output frp_pkg::frp_cmd_t    cmd
);

	localparam int CNT_W = $clog2(MAX_BURST + 1);

	frp_pkg::frp_state_t state_q, state_d;
	frp_pkg::frp_phase_t phase_q, phase_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                pend_q, pend_d, last_q, last_d, ovf_q, ovf_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		count_d = count_q;
		pend_d  = pend_q;
		last_d  = last_q;
		ovf_d   = ovf_q;
		cmd.use_mid = (phase_q == frp_pkg::PH_BISECT);
		unique case (state_q)
			frp_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					count_d = '0;
					phase_d = frp_pkg::PH_NORMAL;
					pend_d  = 1'b0;
					ovf_d   = 1'b0;
					if (st.primed) begin
						state_d = frp_pkg::S_MUL1;
					end
				end
			end
			frp_pkg::S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = frp_pkg::S_MUL2;
			end
			frp_pkg::S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = frp_pkg::S_DIVGO;
			end
			frp_pkg::S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d = frp_pkg::S_DIV;
			end
			frp_pkg::S_DIV: begin
				if (st.div_done) begin
					state_d = frp_pkg::S_RND;
				end
			end
			frp_pkg::S_RND: begin
				cmd.rnd = 1'b1;
				state_d = frp_pkg::S_ADD;
			end
			frp_pkg::S_ADD: begin
				cmd.add = 1'b1;
				state_d = frp_pkg::S_TEST;
			end
			frp_pkg::S_TEST: begin
				unique case (phase_q)
					frp_pkg::PH_NORMAL: begin
						if (st.due) begin
							// The earlier result is known not to be the last one.
							if (pend_q) begin
								last_d  = 1'b0;
								state_d = frp_pkg::S_PUSH;
							end else begin
								state_d = frp_pkg::S_DIFF;
							end
						end else if (pend_q) begin
							last_d  = 1'b1;
							state_d = frp_pkg::S_PUSH;
						end else begin
							state_d = frp_pkg::S_IDLE;
						end
					end
					frp_pkg::PH_PROBE: begin
						if (st.due) begin
							cmd.bis_init = 1'b1;
							ovf_d   = 1'b1;
							phase_d = frp_pkg::PH_BISECT;
							state_d = frp_pkg::S_BISM;
						end else begin
							last_d  = 1'b1;
							state_d = frp_pkg::S_PUSH;
						end
					end
					frp_pkg::PH_BISECT: begin
						cmd.bis_lo = st.due;
						cmd.bis_hi = !st.due;
						state_d = frp_pkg::S_BISM;
					end
					default: state_d = frp_pkg::S_IDLE;
				endcase
			end
			frp_pkg::S_DIFF: begin
				cmd.dcalc = 1'b1;
				state_d   = frp_pkg::S_SUM;
			end
			frp_pkg::S_SUM: begin
				cmd.sum = 1'b1;
				state_d = frp_pkg::S_WGTGO;
			end
			frp_pkg::S_WGTGO: begin
				cmd.wgt_start = 1'b1;
				state_d = frp_pkg::S_WGT;
			end
			frp_pkg::S_WGT: begin
				if (st.wgt_done) begin
					state_d = frp_pkg::S_CHOOSE;
				end
			end
			frp_pkg::S_CHOOSE: begin
				cmd.choose = 1'b1;
				pend_d  = 1'b1;
				count_d = count_q + 1'b1;
				if (count_q == CNT_W'(MAX_BURST - 1)) begin
					phase_d = frp_pkg::PH_PROBE;
				end
				state_d = frp_pkg::S_MUL1;
			end
			frp_pkg::S_PUSH: begin
				if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = last_q;
					cmd.push_ovf  = ovf_q;
					pend_d  = 1'b0;
					state_d = last_q ? frp_pkg::S_IDLE : frp_pkg::S_DIFF;
				end
			end
			frp_pkg::S_BISM: begin
				if (st.bis_more) begin
					cmd.bis_mid = 1'b1;
					state_d = frp_pkg::S_MUL1;
				end else begin
					cmd.idx_from_hi = 1'b1;
					last_d  = 1'b1;
					state_d = frp_pkg::S_PUSH;
				end
			end
			default: state_d = frp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frp_pkg::S_IDLE;
			phase_q <= frp_pkg::PH_NORMAL;
			count_q <= '0;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			last_q  <= last_d;
			ovf_q   <= ovf_d;
		end
	end

	assign in_ready = (state_q == frp_pkg::S_IDLE);

endmodule

FILE: rtl/frame_rate_resample_picker.sv
// Frame rate resample picker: for each source frame time it emits the output
// frames that have become due, with the frame to copy or the blend weights.
// Each wanted time is evaluated with the help of the 62-step serial divider,
// and each output then adds the weights, the choice and the push; a held
// result stalls the engine and the input until it is taken. A cut burst
// adds up to 32 bisection evaluations. The first frame after reset gives no
// output. Depends on frp_pkg, frp_ctrl, frp_datapath and the assertion header.
`include "frame_rate_resample_picker_assert.svh"

module frame_rate_resample_picker #(
	parameter int MAX_BURST = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [frp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [frp_pkg::NUM_W-1:0]          cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// frame_pts
	input  logic [frp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_pts, out_index, source_choice, weight_older, weight_newer
	output logic [frp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tlast,
	// burst_overflow
	output logic                               m_axis_tuser
);

	frp_pkg::frp_cmd_t    cmd;
	frp_pkg::frp_status_t st;
	logic [frp_pkg::CHOICE_W-1:0] out_choice;
	logic [frp_pkg::WGT_W-1:0]    out_wo, out_wn;

	assign out_choice = m_axis_tdata[frp_pkg::CHOICE_LSB +: frp_pkg::CHOICE_W];
	assign out_wo     = m_axis_tdata[frp_pkg::WO_LSB +: frp_pkg::WGT_W];
	assign out_wn     = m_axis_tdata[frp_pkg::WN_LSB +: frp_pkg::WGT_W];

	frp_ctrl #(
		.MAX_BURST (MAX_BURST)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	frp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_pts    (s_axis_tdata[frp_pkg::PTS_W-1:0]),
		.cmd       (cmd),
		.st        (st),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser)
	);

	`FRP_ASSERT_IMPLY(a_ovf_only_on_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "overflow flag on a result that is not the last of its burst")
	`FRP_ASSERT_IMPLY(a_copy_older_weight, clk, arst_n, m_axis_tvalid && (out_choice == frp_pkg::CH_OLDER), out_wn == '0, "older copy with newer weight")
	`FRP_ASSERT_IMPLY(a_copy_newer_weight, clk, arst_n, m_axis_tvalid && (out_choice == frp_pkg::CH_NEWER), out_wo == '0, "newer copy with older weight")
	`FRP_ASSERT_NEXT(a_push_shows, clk, arst_n, cmd.push, m_axis_tvalid, "pushed result not presented on the output")

endmodule

FILE: test/frame_rate_resample_picker_test.sv
// Self-checking testbench for frame_rate_resample_picker: drives source frame times,
// predicts every output frame decision and checks it as it arrives.
// Depends on frp_pkg and the picker RTL only.
`timescale 1ns / 1ps

module frame_rate_resample_picker_test;

	localparam int BURST_CAP = 64;
	localparam int SETTLE_CYCLES = 9000;
	localparam int HOLD_LEN = 4000;

	typedef struct {
		logic [frp_pkg::PTS_W-1:0]    pts;
		logic [frp_pkg::IDX_W-1:0]    idx;
		logic [frp_pkg::CHOICE_W-1:0] choice;
		logic [frp_pkg::WGT_W-1:0]    w_old;
		logic [frp_pkg::WGT_W-1:0]    w_new;
		logic                         last;
		logic                         ovf;
	} pick_t;

	class pick_scoreboard;
		bit [frp_pkg::NUM_W-1:0]  rate_num = 20'd25000;
		bit [frp_pkg::DEN_W-1:0]  rate_den = 10'd1000;
		bit [frp_pkg::MODE_W-1:0] mode = frp_pkg::MODE_NEAREST;
		bit [63:0]       base_time, older, newer;
		int              frames_seen;
		bit [frp_pkg::IDX_W-1:0]  next_idx;
		pick_t           pending_picks[$];
		int              errors, n_out, n_ovf;

		function bit [63:0] wanted(bit [63:0] n);
			bit [63:0] num, p, q, r;
			num = (rate_num != 0) ? 64'(rate_num) : 64'd1;
			p = 64'(rate_den) * 64'd1000000 * n;
			q = p / num;
			r = p % num;
			return base_time + q + (64'd100 * r + 64'd49 * num) / (64'd100 * num);
		endfunction

		function bit is_due(bit [63:0] t);
			return !(t > older && t > newer);
		endfunction

		function bit [frp_pkg::WGT_W-1:0] blend_weight(bit [63:0] a, bit [63:0] s);
			bit [9:0]  q2;
			bit [63:0] rem;
			if (a >= s)
				return frp_pkg::WGT_FULL;
			rem = a;
			q2 = '0;
			for (int i = 0; i < 9; i++) begin
				rem = rem << 1;
				q2 = q2 << 1;
				if (rem >= s) begin
					rem = rem - s;
					q2[0] = 1'b1;
				end
			end
			return frp_pkg::WGT_W'((q2 + 10'd1) >> 1);
		endfunction

		function pick_t decide(bit [63:0] t);
			pick_t     o;
			bit [63:0] d1, d2, s;
			o.pts = t[frp_pkg::PTS_W-1:0];
			o.idx = next_idx;
			o.last = 1'b0;
			o.ovf = 1'b0;
			if (t < older && t < newer) begin
				o.choice = frp_pkg::CH_OLDER; o.w_old = frp_pkg::WGT_FULL; o.w_new = '0;
			end else begin
				d1 = (t > older) ? t - older : older - t;
				d2 = (t > newer) ? t - newer : newer - t;
				if (mode == frp_pkg::MODE_NEAREST) begin
					if (d1 < d2) begin
						o.choice = frp_pkg::CH_OLDER; o.w_old = frp_pkg::WGT_FULL;
						o.w_new = '0;
					end else begin
						o.choice = frp_pkg::CH_NEWER; o.w_old = '0;
						o.w_new = frp_pkg::WGT_FULL;
					end
				end else begin
					s = d1 + d2;
					if (s == 0) begin
						o.choice = frp_pkg::CH_NEWER; o.w_old = '0;
						o.w_new = frp_pkg::WGT_FULL;
					end else begin
						o.w_old = blend_weight(d2, s);
						o.w_new = blend_weight(d1, s);
						if (o.w_old == 0) o.choice = frp_pkg::CH_NEWER;
						else if (o.w_new == 0) o.choice = frp_pkg::CH_OLDER;
						else o.choice = frp_pkg::CH_BLEND;
					end
				end
			end
			return o;
		endfunction

		// Called once per accepted input transaction.
		function void note_frame(bit [frp_pkg::PTS_W-1:0] pts);
			int        count;
			bit [63:0] t, lo, hi, mid;
			pick_t     o;
			older = newer;
			newer = 64'(pts);
			if (frames_seen == 0) begin
				base_time = 64'(pts);
				frames_seen = 1;
				return;
			end
			frames_seen = 2;
			count = 0;
			while (count < BURST_CAP) begin
				t = wanted(64'(next_idx));
				if (!is_due(t))
					break;
				pending_picks.push_back(decide(t));
				next_idx++;
				count++;
			end
			if (count == 0)
				return;
			pending_picks[$].last = 1'b1;
			if (count == BURST_CAP && is_due(wanted(64'(next_idx)))) begin
				pending_picks[$].ovf = 1'b1;
				n_ovf++;
				// Skip every further due index by bisection over the index range.
				lo = 64'(next_idx);
				hi = 64'h1_0000_0000;
				while (hi - lo > 1) begin
					mid = lo + ((hi - lo) >> 1);
					if (is_due(wanted(mid))) lo = mid;
					else hi = mid;
				end
				next_idx = hi[31:0];
			end
		endfunction

		function void check_pick(pick_t got);
			pick_t exp_p;
			n_out++;
			if (pending_picks.size() == 0) begin
				$error("unexpected output transaction: out_pts %0d out_index %0d",
					got.pts, got.idx);
				errors++;
				return;
			end
			exp_p = pending_picks.pop_front();
			if (got.pts !== exp_p.pts) begin
				$error("out_pts: expected %0d, got %0d", exp_p.pts, got.pts); errors++;
			end
			if (got.idx !== exp_p.idx) begin
				$error("out_index: expected %0d, got %0d", exp_p.idx, got.idx); errors++;
			end
			if (got.choice !== exp_p.choice) begin
				$error("source_choice: expected %0d, got %0d", exp_p.choice, got.choice);
				errors++;
			end
			if (got.w_old !== exp_p.w_old) begin
				$error("weight_older: expected %0d, got %0d", exp_p.w_old, got.w_old);
				errors++;
			end
			if (got.w_new !== exp_p.w_new) begin
				$error("weight_newer: expected %0d, got %0d", exp_p.w_new, got.w_new);
				errors++;
			end
			if (got.last !== exp_p.last) begin
				$error("last_of_burst: expected %0d, got %0d", exp_p.last, got.last);
				errors++;
			end
			if (got.ovf !== exp_p.ovf) begin
				$error("burst_overflow: expected %0d, got %0d", exp_p.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic                              clk = 0;
	logic                              arst_n = 0;
	logic                              cfg_we = 0;
	logic [frp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [frp_pkg::NUM_W-1:0]         cfg_wdata = '0;
	logic                              s_axis_tvalid = 0;
	logic                              s_axis_tready;
	logic [frp_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 0;
	logic [frp_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
	logic                              m_axis_tlast;
	logic                              m_axis_tuser;

	pick_scoreboard sb = new;
	int tx_idle_pct = 11;
	int rx_idle_pct = 70;
	// The stimulus toggles hold_req to ask the receiver for a long hold-off.
	bit hold_req = 0;
	bit hold_seen = 0;
	int hold_cycles = 0;
	int n_frames = 0;

	frame_rate_resample_picker u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cycles <= HOLD_LEN;
			m_axis_tready <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		pick_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.pts    = m_axis_tdata[frp_pkg::PTS_LSB +: frp_pkg::PTS_W];
			got.idx    = m_axis_tdata[frp_pkg::IDX_LSB +: frp_pkg::IDX_W];
			got.choice = m_axis_tdata[frp_pkg::CHOICE_LSB +: frp_pkg::CHOICE_W];
			got.w_old  = m_axis_tdata[frp_pkg::WO_LSB +: frp_pkg::WGT_W];
			got.w_new  = m_axis_tdata[frp_pkg::WN_LSB +: frp_pkg::WGT_W];
			got.last   = m_axis_tlast;
			got.ovf    = m_axis_tuser;
			sb.check_pick(got);
		end
	end

	task automatic send_frame(logic [frp_pkg::PTS_W-1:0] pts);
		s_axis_tvalid <= 1;
		s_axis_tdata <= frp_pkg::IN_DATA_W'(pts);
		do @(posedge clk); while (!s_axis_tready);
		sb.note_frame(pts);
		n_frames++;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Lets the block drain and finish any burst that ends with no output.
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [frp_pkg::CFG_IDX_W-1:0] idx,
		logic [frp_pkg::NUM_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			frp_pkg::CFG_RATE_NUM: sb.rate_num = val;
			frp_pkg::CFG_RATE_DEN: sb.rate_den = val[frp_pkg::DEN_W-1:0];
			frp_pkg::CFG_MODE:     sb.mode = val[frp_pkg::MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_rate(int num, int den, int mode);
		drain();
		write_reg(frp_pkg::CFG_RATE_NUM, frp_pkg::NUM_W'(num));
		write_reg(frp_pkg::CFG_RATE_DEN, frp_pkg::NUM_W'(den));
		write_reg(frp_pkg::CFG_MODE, frp_pkg::NUM_W'(mode));
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Frame time near a chosen output time, so bursts stay short but varied.
	task automatic random_frame();
		bit [63:0] period, t;
		int        roll;
		period = (64'(sb.rate_den) * 64'd1000000) / ((sb.rate_num != 0) ?
			64'(sb.rate_num) : 64'd1) + 64'd1;
		roll = $urandom_range(99);
		if (roll < 4) begin
			send_frame(frp_pkg::PTS_W'({$urandom, $urandom}));
		end else if (roll < 9) begin
			send_frame(frp_pkg::PTS_W'(sb.older - 64'($urandom_range(0, 1000))));
		end else begin
			t = sb.wanted(64'(sb.next_idx) + 64'($urandom_range(0, 3)));
			t = t + 64'($urandom_range(0, 32'(period))) - period / 2;
			send_frame(t[frp_pkg::PTS_W-1:0]);
		end
	endtask

	initial begin
		int phase_num[6]  = '{25000, 30000, 1000000, 1, 24000, 60000};
		int phase_den[6]  = '{1000, 1001, 1, 1001, 1001, 1000};
		int phase_mode[6] = '{1, 0, 2, 1, 3, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: base time, tie, out-of-order, full-range jump with index wrap,
		// then an output earlier than both frames.
		send_frame(63'd1000);
		send_frame(63'd41000);
		send_frame(63'd61000);
		send_frame(63'd101000);
		send_frame(63'd0);
		send_frame(63'd200000);
		send_frame({63{1'b1}});
		send_frame(63'd5000);
		set_rate(25000, 1000, 1);
		send_frame(63'd15000);
		send_frame(63'd55000);
		send_frame(63'd90000);
		set_rate(0, 1023, 3);
		send_frame(63'd1500000);
		send_frame(63'd3100000);
		set_rate(1000000, 0, 1);
		send_frame(63'd2000);
		set_rate(25000, 1000, 0);
		send_frame(63'd20000);

		for (int p = 0; p < 6; p++) begin
			set_rate(phase_num[p], phase_den[p], phase_mode[p]);
			if (p == 0) begin
				// Long receiver hold-off while frames keep coming.
				hold_req = !hold_req;
			end else if (p == 2) begin
				tx_idle_pct = 70; rx_idle_pct = 11;
			end else if (p == 4) begin
				tx_idle_pct = 0; rx_idle_pct = 0;
			end
			for (int i = 0; i < 36; i++)
				random_frame();
		end

		drain();
		$display("Covered %0d frames and %0d output frames (%0d cut bursts)",
			n_frames, sb.n_out, sb.n_ovf);
		$display("over six rate/mode settings with idle, stall and hold-off patterns.");
		if (sb.errors == 0 && sb.pending_picks.size() == 0)
			$display("frame_rate_resample_picker_test: done, clean");
		else
			$display("frame_rate_resample_picker_test: done, errors");
		$finish;
	end

	initial begin
		#100ms;
		$display("frame_rate_resample_picker_test: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/frp_pkg.sv
rtl/frp_divider.sv
rtl/frp_datapath.sv
rtl/frp_ctrl.sv
rtl/frame_rate_resample_picker.sv
test/frame_rate_resample_picker_test.sv
